FILE: rtl/e8p_pkg.sv
package e8p_pkg;

  localparam int CB_SIZE     = 256;
  localparam int CB_NORM_MAX = 48;
  localparam int LANES       = 8;
  localparam int W_BITS      = 16;

  // configuration register indexes
  localparam logic REG_RESIDUAL_MODE = 1'b0;
  localparam logic REG_INV_SCALE     = 1'b1;

  localparam logic [15:0] INV_SCALE_RESET = 16'd18997;

  typedef logic [CB_SIZE-1:0][15:0] cb_rom_t;

  // one decoded 16-bit subcode: codebook entry plus effective signs
  typedef struct packed {
    logic [15:0] entry;
    logic [7:0]  signs;
    logic        par;
  } sub_dec_t;

  // what one lane needs from one subcode
  typedef struct packed {
    logic [1:0] dig;
    logic       neg;
    logic       par;
  } lane_in_t;

  // tuples ordered by norm, then lexicographically with coordinate 0 most significant
  function automatic cb_rom_t build_cb();
    cb_rom_t     rom;
    int unsigned counts [CB_NORM_MAX+1];
    int unsigned nxt [CB_NORM_MAX+1];
    int unsigned acc;
    int unsigned odd;
    int unsigned n4;
    int unsigned pos;
    int unsigned d;
    int unsigned m;
    int unsigned t;
    logic [15:0] pk;
    rom = '0;
    acc = 0;
    for (int s = 0; s <= CB_NORM_MAX; s++) begin
      counts[s] = 0;
      nxt[s] = 0;
    end
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        acc = 0;
        for (int s = 0; s <= CB_NORM_MAX; s++) begin
          nxt[s] = acc;
          acc = acc + counts[s];
        end
      end
      // tuple number split in two bytes, high byte outer, so order is kept
      for (int th = 0; th < 256; th++) begin
        for (int tl = 0; tl < 256; tl++) begin
          t = th * 256 + tl;
          odd = 0;
          n4 = 0;
          pk = '0;
          for (int k = 0; k < 8; k++) begin
            d = (t >> (14 - 2 * k)) & 3;
            m = 2 * d + 1;
            odd = odd + (d & 1);
            n4 = n4 + m * m;
            pk[2*k +: 2] = 2'(d);
          end
          if (odd[0] == 1'b0 && n4 <= CB_NORM_MAX) begin
            if (pass == 0) begin
              counts[n4] = counts[n4] + 1;
            end else begin
              pos = nxt[n4];
              nxt[n4] = nxt[n4] + 1;
              if (pos < CB_SIZE) rom[pos[7:0]] = pk;
            end
          end
        end
      end
    end
    return rom;
  endfunction

  localparam cb_rom_t CB_ROM = build_cb();

endpackage

FILE: rtl/e8p_sub_dec.sv
module e8p_sub_dec (
  input  logic [15:0]       code,
  output e8p_pkg::sub_dec_t dec
);

  logic par;

  assign par       = ^code[7:0];
  assign dec.par   = par;
  // parity only flips the sign of coordinate 0
  assign dec.signs = code[7:0] ^ {7'b0, par};
  assign dec.entry = e8p_pkg::CB_ROM[code[15:8]];

endmodule

FILE: rtl/e8p_lane.sv
module e8p_lane (
  input  logic               clk,
  input  logic               en,
  input  e8p_pkg::lane_in_t  fine_in,
  input  e8p_pkg::lane_in_t  coarse_in,
  input  logic [15:0]        scale,
  input  logic               mode,
  output logic signed [15:0] w
);

  logic signed [4:0]  mag_f, mag_c;
  logic signed [4:0]  qf, qc;
  logic signed [4:0]  qf_r, qc_r;
  logic signed [21:0] prod_r;
  logic signed [22:0] rnd;
  logic signed [16:0] coarse_w, fine_w, single_w;

  // coordinate in quarters: +-(4d+2) +-1
  assign mag_f = $signed({1'b0, fine_in.dig, 2'b10});
  assign mag_c = $signed({1'b0, coarse_in.dig, 2'b10});
  assign qf = (fine_in.neg ? -mag_f : mag_f) + (fine_in.par ? -5'sd1 : 5'sd1);
  assign qc = (coarse_in.neg ? -mag_c : mag_c) + (coarse_in.par ? -5'sd1 : 5'sd1);

  always_ff @(posedge clk) begin
    if (en) begin
      qf_r   <= qf;
      qc_r   <= qc;
      prod_r <= 22'(qf) * $signed({6'b0, scale});
    end
  end

  // floor((p + 32) / 64), ties toward plus infinity
  assign rnd      = 23'(prod_r) + 23'sd32;
  assign fine_w   = 17'(rnd >>> 6);
  assign coarse_w = 17'(qc_r) <<< 10;
  assign single_w = 17'(qf_r) <<< 10;
  assign w = mode ? 16'(coarse_w + fine_w) : 16'(single_w);

endmodule

FILE: rtl/e8p_merge.sv
module e8p_merge (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  logic                                   vin,
  input  logic [e8p_pkg::LANES-1:0][e8p_pkg::W_BITS-1:0] w,
  output logic                                   tvalid,
  output logic [e8p_pkg::LANES*e8p_pkg::W_BITS-1:0] tdata
);

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (load) begin
      tvalid <= vin;
    end
  end

  // lane 0 lands in the lowest bits
  always_ff @(posedge clk) begin
    if (load) begin
      tdata <= w;
    end
  end

endmodule

FILE: rtl/e8p_lattice_rvq_decoder_core.sv
// channel   dir  handshake               payload
// s_axis    in   s_tvalid / s_tready     s_tdata[31:0]: packed_code
// m_axis    out  m_tvalid / m_tready     m_tdata[127:0]: weight_0 .. weight_7
// cfg       in   cfg_we                  cfg_index[0:0], cfg_data[15:0]
//
// one code per cycle sustained while m_tready stays high; a beat passes the
// input reg, codebook lookup, lane multiply and output reg in that order.
// each stage advances when empty or when the stage after it moves, so bubbles
// close up and s_tready drops only with all four stages full and m_tready low.
// rst is synchronous; it clears all stage valids and restores the config defaults.
module e8p_lattice_rvq_decoder_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [31:0] packed_code
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // weight_0 [15:0] up to weight_7 [127:112]
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);

  logic        residual_mode;
  logic [15:0] inv_scale;

  logic va, vb, vc;
  logic ra, rb, rc, rd;
  logic [31:0] code_a;
  e8p_pkg::sub_dec_t fine_dec, coarse_dec;
  e8p_pkg::sub_dec_t fine_b, coarse_b;
  logic [e8p_pkg::LANES-1:0][e8p_pkg::W_BITS-1:0] lane_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      residual_mode <= 1'b1;
      inv_scale     <= e8p_pkg::INV_SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        e8p_pkg::REG_RESIDUAL_MODE: residual_mode <= cfg_data[0];
        e8p_pkg::REG_INV_SCALE:     inv_scale     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rd = !m_tvalid || m_tready;
  assign rc = !vc || rd;
  assign rb = !vb || rc;
  assign ra = !va || rb;
  assign s_tready = ra;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (ra) va <= s_tvalid;
      if (rb) vb <= va;
      if (rc) vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (ra) code_a <= s_tdata;
    if (rb) begin
      fine_b   <= fine_dec;
      coarse_b <= coarse_dec;
    end
  end

  e8p_sub_dec u_dec_fine (
    .code (code_a[15:0]),
    .dec  (fine_dec)
  );

  e8p_sub_dec u_dec_coarse (
    .code (code_a[31:16]),
    .dec  (coarse_dec)
  );

  for (genvar k = 0; k < e8p_pkg::LANES; k++) begin : g_lane
    e8p_pkg::lane_in_t fin, cin;
    assign fin = '{dig: fine_b.entry[2*k +: 2], neg: fine_b.signs[k], par: fine_b.par};
    assign cin = '{dig: coarse_b.entry[2*k +: 2], neg: coarse_b.signs[k],
                   par: coarse_b.par};
    e8p_lane u_lane (
      .clk       (clk),
      .en        (rc),
      .fine_in   (fin),
      .coarse_in (cin),
      .scale     (inv_scale),
      .mode      (residual_mode),
      .w         (lane_w[k])
    );
  end

  e8p_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .load   (rd),
    .vin    (vc),
    .w      (lane_w),
    .tvalid (m_tvalid),
    .tdata  (m_tdata)
  );

`ifndef ASSERT_OFF
  // input is only refused when every stage holds a beat and the output stalls
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (va && vb && vc && m_tvalid && !m_tready))
    else $error("s_tready low with a free stage");

  // a stalled lane stage keeps its beat
  a_lane_hold: assert property (@(posedge clk) disable iff (rst)
    (vc && !rc) |=> vc)
    else $error("lane stage dropped a stalled beat");

  // config registers come out of reset at their defaults
  a_cfg_reset: assert property (@(posedge clk)
    $past(rst) |-> (residual_mode && inv_scale == e8p_pkg::INV_SCALE_RESET))
    else $error("config registers not at reset values");
`endif

endmodule

FILE: tb/sv/tb_e8p_lattice_rvq_decoder_core.sv
`timescale 1ns / 1ps

class weight_checker;
  logic [15:0]  lattice_rom [256];
  bit           resid_on;
  logic [15:0]  inv_scale;
  // {code, weight_7 .. weight_0}
  logic [159:0] expected_weights [$];
  int           errors;
  int           shown;

  function new();
    build_rom();
    resid_on  = 1'b1;
    inv_scale = e8p_pkg::INV_SCALE_RESET;
    errors    = 0;
    shown     = 0;
  endfunction

  // even-odd-count tuples, grouped by norm, lexicographic inside a group
  function void build_rom();
    int unsigned per_norm [49];
    int unsigned base [49];
    int unsigned acc;
    int unsigned odd;
    int unsigned n4;
    int unsigned d;
    int unsigned slot;
    logic [15:0] ent;
    for (int s = 0; s <= 48; s++) per_norm[s] = 0;
    for (int i = 0; i < 256; i++) lattice_rom[i] = '0;
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        acc = 0;
        for (int s = 0; s <= 48; s++) begin
          base[s] = acc;
          acc = acc + per_norm[s];
        end
      end
      for (int t = 0; t < 65536; t++) begin
        odd = 0;
        n4  = 0;
        ent = '0;
        for (int k = 0; k < 8; k++) begin
          d = (t >> (14 - 2 * k)) & 3;
          odd = odd + (d & 1);
          n4 = n4 + (2 * d + 1) * (2 * d + 1);
          ent[2*k +: 2] = d[1:0];
        end
        if ((odd & 1) == 0 && n4 <= 48) begin
          if (pass == 0) begin
            per_norm[n4]++;
          end else begin
            slot = base[n4];
            base[n4]++;
            if (slot < 256) lattice_rom[slot] = ent;
          end
        end
      end
    end
  endfunction

  function void write_reg(logic idx, logic [15:0] val);
    if (idx == e8p_pkg::REG_RESIDUAL_MODE) begin
      resid_on = val[0];
    end else begin
      inv_scale = val;
    end
  endfunction

  // eight signed coordinates in quarters, one byte each
  function logic [7:0][7:0] subcode_quarters(logic [15:0] sc);
    logic [7:0][7:0] q;
    logic [15:0]     ent;
    logic [7:0]      flips;
    logic            par;
    int              mag;
    int              v;
    ent   = lattice_rom[sc[15:8]];
    par   = ^sc[7:0];
    flips = sc[7:0] ^ {7'd0, par};
    for (int k = 0; k < 8; k++) begin
      mag = 4 * int'(ent[2*k +: 2]) + 2;
      v = flips[k] ? -mag : mag;
      v = par ? v - 1 : v + 1;
      q[k] = v[7:0];
    end
    return q;
  endfunction

  function logic [127:0] predict_weights(logic [31:0] code);
    logic [7:0][7:0]  cq;
    logic [7:0][7:0]  fq;
    logic [127:0]     w;
    longint           prod;
    longint           acc;
    cq = subcode_quarters(code[31:16]);
    fq = subcode_quarters(code[15:0]);
    for (int k = 0; k < 8; k++) begin
      if (resid_on) begin
        prod = longint'($signed(fq[k])) * longint'({48'd0, inv_scale});
        acc  = longint'($signed(cq[k])) * 1024 + ((prod + 32) >>> 6);
      end else begin
        acc = longint'($signed(fq[k])) * 1024;
      end
      w[16*k +: 16] = acc[15:0];
    end
    return w;
  endfunction

  function void note_code(logic [31:0] code);
    expected_weights.push_back({code, predict_weights(code)});
  endfunction

  function void report(string msg);
    errors++;
    if (shown < 40) begin
      $display("mismatch: %s", msg);
      shown++;
    end
  endfunction

  function void check_weights(logic [127:0] got);
    logic [159:0] exp_beat;
    if (expected_weights.size() == 0) begin
      report($sformatf("output beat %h with no code pending", got));
      return;
    end
    exp_beat = expected_weights.pop_front();
    for (int k = 0; k < 8; k++) begin
      if (got[16*k +: 16] !== exp_beat[16*k +: 16])
        report($sformatf("code %h weight_%0d got %0d want %0d", exp_beat[159:128], k,
                         $signed(got[16*k +: 16]), $signed(exp_beat[16*k +: 16])));
    end
  endfunction

  function int pending();
    return expected_weights.size();
  endfunction
endclass

module tb_e8p_lattice_rvq_decoder_core;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;   // [31:0] packed_code
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;        // weight_0 [15:0] up to weight_7 [127:112]
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [15:0]  cfg_data = '0;

  weight_checker board;

  int          burst_left = 0;
  int          rdy_mode = 0;
  int unsigned rdy_cnt = 0;

  e8p_lattice_rvq_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver backpressure: switches between always ready, coin flip, mostly stalled
  // and a fixed on/off pattern
  always @(posedge clk) begin
    if (rdy_cnt == 0) begin
      rdy_mode <= $urandom_range(0, 3);
      rdy_cnt  <= $urandom_range(16, 96);
    end else begin
      rdy_cnt <= rdy_cnt - 1;
    end
    case (rdy_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (rdy_cnt[2:0] != 3'd0 && rdy_cnt[2:0] != 3'd3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_code(s_tdata);
      if (m_tvalid && m_tready) board.check_weights(m_tdata);
    end
  end

  task automatic send_code(input logic [31:0] code);
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // bursts with random gaps; long bursts give stretches without idling
  task automatic send_paced(input logic [31:0] code);
    int gap;
    send_code(code);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 5);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] mode_data, input logic [15:0] scale);
    cfg_we    <= 1'b1;
    cfg_index <= e8p_pkg::REG_RESIDUAL_MODE;
    cfg_data  <= mode_data;
    @(posedge clk);
    board.write_reg(e8p_pkg::REG_RESIDUAL_MODE, mode_data);
    cfg_index <= e8p_pkg::REG_INV_SCALE;
    cfg_data  <= scale;
    @(posedge clk);
    board.write_reg(e8p_pkg::REG_INV_SCALE, scale);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_code();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 9))
      0: c[31:24] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      1: c[15:8]  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: begin
        c[23:16] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        c[7:0]   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: ;
    endcase
    return c;
  endfunction

  logic [31:0] resid_dir [14] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_FF00, 32'hFF00_00FF,
    32'h0001_0080, 32'h0080_0001, 32'h8055_7FAA, 32'h7FAA_8055,
    32'h01FE_FE01, 32'hFF7F_00FE, 32'h00FE_FF7F, 32'hC3C3_3C3C,
    32'h0F0F_F0F0, 32'h5A00_A5FF
  };
  logic [31:0] single_dir [6] = '{
    32'h1234_5678, 32'hEDCB_5678, 32'h0000_FFFF, 32'hFFFF_0000,
    32'hFFFF_FF01, 32'h0000_0080
  };
  logic [15:0] mode_set  [7] = '{16'h0001, 16'h0000, 16'hFFFF, 16'h0001,
                                 16'h8001, 16'hFFFE, 16'h0001};
  logic [15:0] scale_set [7];

  initial begin
    board = new();
    scale_set = '{e8p_pkg::INV_SCALE_RESET, 16'($urandom), 16'h0000, 16'hFFFF,
                  16'($urandom), 16'hFFFF, 16'($urandom_range(1, 255))};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings first: residual mode with the default scale
    foreach (resid_dir[i]) send_code(resid_dir[i]);
    drain();
    // single mode, written with the upper data bits set
    program_regs(16'hFFFE, 16'hFFFF);
    foreach (single_dir[i]) send_code(single_dir[i]);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      program_regs(mode_set[ph], scale_set[ph]);
      for (int n = 0; n < 100; n++) send_paced(random_code());
      drain();
    end

    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/e8p_pkg.sv
rtl/e8p_sub_dec.sv
rtl/e8p_lane.sv
rtl/e8p_merge.sv
rtl/e8p_lattice_rvq_decoder_core.sv
tb/sv/tb_e8p_lattice_rvq_decoder_core.sv
